@@ hw/rtl/rtcc_pkg.sv @@
// Shared types, codes and constants for the real-time clock calendar block.
// No dependencies; every other file in hw/rtl imports this package.
package rtcc_pkg;

    // Operation codes carried in the input beat.
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_SET  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_COUNT_MODE = 1'b0;
    localparam logic CFG_TICKS_PER_SEC = 1'b1;

    localparam int CFG_DATA_W = 8;
    localparam int EVENT_W = 9;

    // Event bit positions.
    localparam int EV_SECOND   = 0;
    localparam int EV_TEN_SEC  = 1;
    localparam int EV_MINUTE   = 2;
    localparam int EV_MIN5     = 3;
    localparam int EV_MIN10    = 4;
    localparam int EV_MIN15    = 5;
    localparam int EV_HOUR     = 6;
    localparam int EV_HOUR2    = 7;
    localparam int EV_MIDNIGHT = 8;

    localparam logic [13:0] YEAR_MAX = 14'd9999;

    // State after reset.
    localparam logic [13:0] RST_YEAR   = 14'd2024;
    localparam logic [3:0]  RST_MONTH  = 4'd4;
    localparam logic [4:0]  RST_DAY    = 5'd17;
    localparam logic [4:0]  RST_HOUR   = 5'd13;
    localparam logic [5:0]  RST_MINUTE = 6'd53;
    localparam logic [5:0]  RST_SECOND = 6'd0;
    localparam logic [7:0]  RST_TICKS_PER_SEC = 8'd50;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_time;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] fine_count;
        logic [13:0] new_year;
        logic [7:0]  new_month;
        logic [7:0]  new_day;
        logic [7:0]  new_hour;
        logic [7:0]  new_minute;
        logic [7:0]  new_second;
    } t_in_item;

    typedef struct packed {
        logic [13:0]        year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic [5:0]         second;
        logic               set_accepted;
        logic [EVENT_W-1:0] period_events;
    } t_out_item;

    // Length of a month; codes outside 1..12 read as 31 days.
    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] days;
        case (month)
            4'd2: days = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: days = 5'd30;
            default: days = 5'd31;
        endcase
        return days;
    endfunction

endpackage

@@ hw/rtl/rtcc_advance.sv @@
// One-second advance of the calendar with Gregorian rollover and event flags.
// Depends on rtcc_pkg for the time type and month lengths.
module rtcc_advance (
    input  rtcc_pkg::t_time                   i_cur,
    output rtcc_pkg::t_time                   o_next,
    output logic [rtcc_pkg::EVENT_W-1:0]      o_events
);
    import rtcc_pkg::*;

    logic [6:0]  sec_inc;
    logic [6:0]  min_inc;
    logic [5:0]  hour_inc;
    logic [5:0]  day_inc;
    logic [4:0]  month_inc;
    logic        sec_wrap;
    logic        min_wrap;
    logic        hour_wrap;
    logic        day_wrap;
    logic        month_wrap;
    logic [13:0] inv_prod;
    logic        div25;
    logic        leap;
    logic        ten_sec;
    logic        min5;
    logic        min10;
    logic        min15;

    // Multiplying by the inverse of 25 modulo 2^14 maps the multiples of 25
    // onto the lowest 656 codes, so divisibility needs no divider.
    assign inv_prod = i_cur.year * 14'd7209;
    assign div25    = inv_prod <= 14'd655;
    assign leap     = (i_cur.year[1:0] == 2'd0) && (!div25 || (i_cur.year[3:0] == 4'd0));

    assign sec_inc   = 7'(i_cur.second) + 7'd1;
    assign min_inc   = 7'(i_cur.minute) + 7'd1;
    assign hour_inc  = 6'(i_cur.hour) + 6'd1;
    assign day_inc   = 6'(i_cur.day) + 6'd1;
    assign month_inc = 5'(i_cur.month) + 5'd1;

    assign sec_wrap   = sec_inc >= 7'd60;
    assign min_wrap   = sec_wrap && (min_inc >= 7'd60);
    assign hour_wrap  = min_wrap && (hour_inc >= 6'd24);
    assign day_wrap   = hour_wrap && (day_inc > 6'(month_days(i_cur.month, leap)));
    assign month_wrap = day_wrap && (month_inc > 5'd12);

    always_comb begin
        o_next.second = sec_wrap ? 6'd0 : sec_inc[5:0];
        o_next.minute = !sec_wrap ? i_cur.minute : (min_wrap ? 6'd0 : min_inc[5:0]);
        o_next.hour   = !min_wrap ? i_cur.hour : (hour_wrap ? 5'd0 : hour_inc[4:0]);
        o_next.day    = !hour_wrap ? i_cur.day : (day_wrap ? 5'd1 : day_inc[4:0]);
        o_next.month  = !day_wrap ? i_cur.month : (month_wrap ? 4'd1 : month_inc[3:0]);
        o_next.year   = i_cur.year;
        if (month_wrap && (i_cur.year < YEAR_MAX)) begin
            o_next.year = i_cur.year + 14'd1;
        end
    end

    always_comb begin
        ten_sec = o_next.second inside {6'd0, 6'd10, 6'd20, 6'd30, 6'd40, 6'd50};
        min5  = o_next.minute inside {6'd0, 6'd5, 6'd10, 6'd15, 6'd20, 6'd25,
                                      6'd30, 6'd35, 6'd40, 6'd45, 6'd50, 6'd55};
        min10 = o_next.minute inside {6'd0, 6'd10, 6'd20, 6'd30, 6'd40, 6'd50};
        min15 = o_next.minute inside {6'd0, 6'd15, 6'd30, 6'd45};

        o_events              = '0;
        o_events[EV_SECOND]   = 1'b1;
        o_events[EV_TEN_SEC]  = ten_sec;
        o_events[EV_MINUTE]   = sec_wrap;
        o_events[EV_MIN5]     = sec_wrap && min5;
        o_events[EV_MIN10]    = sec_wrap && min10;
        o_events[EV_MIN15]    = sec_wrap && min15;
        o_events[EV_HOUR]     = min_wrap;
        o_events[EV_HOUR2]    = min_wrap && !o_next.hour[0];
        o_events[EV_MIDNIGHT] = min_wrap && (o_next.hour == 5'd0);
    end

endmodule

@@ hw/rtl/rtc_calendar_with_period_events_unit.sv @@
// Real-time clock calendar: tick, validated set and read with period events.
// An accepted beat waits in the input register until the result register is free,
// and is then processed into the result register, where its result is offered.
// Throughput: one beat per cycle; the input register keeps taking beats while
// a result waits, and stalls only when both registers are full.
// Reset (synchronous, active low) loads 2024-04-17 13:53:00, clears the fine
// count reference, sets count mode off and 50 counts per second.
module rtc_calendar_with_period_events_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  rtcc_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output rtcc_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_idx,
    input  logic [rtcc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import rtcc_pkg::*;

    logic                r_count_mode;
    logic [7:0]          r_ticks_per_sec;
    t_time               r_time;
    t_time               n_time;
    logic [31:0]         r_last_fine;
    logic [31:0]         n_last_fine;
    logic                r_in_valid;
    t_in_item            r_in_item;
    logic                r_out_valid;
    t_out_item           r_out_item;
    t_out_item           n_out_item;

    t_time               adv_time;
    logic [EVENT_W-1:0]  adv_events;
    logic                out_free;
    logic                process;
    logic                in_accept;
    logic [31:0]         fine_diff;
    logic [31:0]         fine_mag;
    logic                tick_go;
    logic                set_leap;
    logic                set_ok;

    rtcc_advance u_advance (
        .i_cur    (r_time),
        .o_next   (adv_time),
        .o_events (adv_events)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign process    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    // The fine-count distance is a signed 32-bit difference; its magnitude at
    // the most negative value stays 2^31, which still compares as large.
    assign fine_diff = r_in_item.fine_count - r_last_fine;
    assign fine_mag  = fine_diff[31] ? (32'd0 - fine_diff) : fine_diff;
    assign tick_go   = (r_in_item.operation == OP_TICK) &&
                       (!r_count_mode || (fine_mag >= 32'(r_ticks_per_sec)));

    // A set checks the month length with the two-digit-year leap rule.
    assign set_leap = r_in_item.new_year[1:0] == 2'd0;
    assign set_ok   = (r_in_item.operation == OP_SET) &&
                      (r_in_item.new_year != 14'd0) && (r_in_item.new_year <= YEAR_MAX) &&
                      (r_in_item.new_month != 8'd0) && (r_in_item.new_month <= 8'd12) &&
                      (r_in_item.new_day != 8'd0) &&
                      (r_in_item.new_day <= 8'(month_days(r_in_item.new_month[3:0], set_leap))) &&
                      (r_in_item.new_hour <= 8'd23) &&
                      (r_in_item.new_minute <= 8'd59) &&
                      (r_in_item.new_second <= 8'd59);

    always_comb begin
        n_time      = r_time;
        n_last_fine = r_last_fine;
        if (tick_go) begin
            n_time = adv_time;
            // The fine-count reference only moves on a count-mode advance.
            if (r_count_mode) begin
                n_last_fine = r_in_item.fine_count;
            end
        end else if (set_ok) begin
            n_time.year   = r_in_item.new_year;
            n_time.month  = r_in_item.new_month[3:0];
            n_time.day    = r_in_item.new_day[4:0];
            n_time.hour   = r_in_item.new_hour[4:0];
            n_time.minute = r_in_item.new_minute[5:0];
            n_time.second = r_in_item.new_second[5:0];
        end

        n_out_item.year          = n_time.year;
        n_out_item.month         = n_time.month;
        n_out_item.day           = n_time.day;
        n_out_item.hour          = n_time.hour;
        n_out_item.minute        = n_time.minute;
        n_out_item.second        = n_time.second;
        n_out_item.set_accepted  = set_ok;
        n_out_item.period_events = tick_go ? adv_events : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_mode    <= 1'b0;
            r_ticks_per_sec <= RST_TICKS_PER_SEC;
            r_time.year     <= RST_YEAR;
            r_time.month    <= RST_MONTH;
            r_time.day      <= RST_DAY;
            r_time.hour     <= RST_HOUR;
            r_time.minute   <= RST_MINUTE;
            r_time.second   <= RST_SECOND;
            r_last_fine     <= 32'd0;
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_COUNT_MODE:    r_count_mode    <= i_cfg_wdata[0];
                    CFG_TICKS_PER_SEC: r_ticks_per_sec <= i_cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (process) begin
                r_time      <= n_time;
                r_last_fine <= n_last_fine;
            end
            r_in_valid  <= in_accept || (r_in_valid && !process);
            r_out_valid <= process || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item <= i_in_item;
        end
        if (process) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

@@ hw/rtl/rtcc_checker.sv @@
// Port-level assertions for the clock calendar top level, attached by bind.
// Depends on rtcc_pkg and on rtc_calendar_with_period_events_unit.
module rtcc_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  rtcc_pkg::t_out_item                 o_out_item
);
    import rtcc_pkg::*;

    // A result that is held back stays on the port unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result beat changed while stalled");

    // A loaded set never raises period events.
    a_set_no_events: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.set_accepted |-> o_out_item.period_events == '0)
        else $error("set beat carries period events");

    // Any event comes from a second advance, and a minute change means second zero.
    a_event_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.period_events != '0) |->
            o_out_item.period_events[EV_SECOND] &&
            (!o_out_item.period_events[EV_MINUTE] || (o_out_item.second == 6'd0)))
        else $error("period events out of order");

    // The reported month, hour, minute and second are legal, the day is nonzero and the year is at most the maximum.
    a_time_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.month != 4'd0) && (o_out_item.month <= 4'd12) &&
            (o_out_item.day != 5'd0) && (o_out_item.hour <= 5'd23) &&
            (o_out_item.minute <= 6'd59) && (o_out_item.second <= 6'd59) &&
            (o_out_item.year <= YEAR_MAX))
        else $error("illegal calendar time on the result port");

endmodule

bind rtc_calendar_with_period_events_unit rtcc_checker u_rtcc_checker (.*);

@@ dv/rtc_calendar_with_period_events_unit_tb.sv @@
`timescale 1ns / 100ps
// Testbench for the real-time clock calendar unit: sends ticks, sets and reads, predicts
// the time and period events returned for each beat, and checks every result beat.
// Depends on rtcc_pkg and rtc_calendar_with_period_events_unit.
module rtc_calendar_with_period_events_unit_tb;
    import rtcc_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_item = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_item;
    logic                  i_cfg_we = 1'b0;
    logic                  i_cfg_idx = CFG_COUNT_MODE;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // Calendar as the block should hold it.
    logic [13:0] cal_year;
    logic [3:0]  cal_month;
    logic [4:0]  cal_day;
    logic [4:0]  cal_hour;
    logic [5:0]  cal_minute;
    logic [5:0]  cal_second;
    logic [31:0] fine_ref;
    logic        cfg_count_mode;
    logic [7:0]  cfg_ticks;

    t_out_item   calendar_readings[$];
    t_out_item   reading_due;
    int          n_fail = 0;
    bit          quiet = 1'b0;
    int          stall_left = 0;
    logic [31:0] fine_now = '0;

    rtc_calendar_with_period_events_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    task automatic reset_calendar();
        cal_year = RST_YEAR;
        cal_month = RST_MONTH;
        cal_day = RST_DAY;
        cal_hour = RST_HOUR;
        cal_minute = RST_MINUTE;
        cal_second = RST_SECOND;
        fine_ref = '0;
        cfg_count_mode = 1'b0;
        cfg_ticks = RST_TICKS_PER_SEC;
    endtask

    function automatic bit gregorian_leap(input int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int unsigned month_length(input int unsigned m, input bit leap);
        case (m)
            2: return leap ? 29 : 28;
            4, 6, 9, 11: return 30;
            default: return 31;
        endcase
    endfunction

    // A set is checked with the two-digit year rule, not the Gregorian one.
    function automatic bit set_is_valid(input t_in_item it);
        int unsigned y;
        int unsigned mo;
        int unsigned d;
        y = it.new_year;
        mo = it.new_month;
        d = it.new_day;
        if (y == 0 || y > YEAR_MAX) return 1'b0;
        if (mo < 1 || mo > 12 || d == 0) return 1'b0;
        if (d > month_length(mo, (y % 100) % 4 == 0)) return 1'b0;
        if (it.new_hour > 23 || it.new_minute > 59 || it.new_second > 59) return 1'b0;
        return 1'b1;
    endfunction

    task automatic advance_second(output logic [EVENT_W-1:0] ev);
        int unsigned sec;
        int unsigned mnt;
        int unsigned hr;
        int unsigned dy;
        int unsigned mon;
        int unsigned yr;
        ev = '0;
        ev[EV_SECOND] = 1'b1;
        sec = cal_second + 1;
        mnt = cal_minute;
        hr = cal_hour;
        dy = cal_day;
        mon = cal_month;
        yr = cal_year;
        if (sec >= 60) begin
            sec = 0;
            mnt++;
            ev[EV_MINUTE] = 1'b1;
            if (mnt >= 60) begin
                mnt = 0;
                hr++;
                ev[EV_HOUR] = 1'b1;
                if (hr >= 24) begin
                    hr = 0;
                    dy++;
                    if (dy > month_length(mon, gregorian_leap(yr))) begin
                        dy = 1;
                        mon++;
                        if (mon > 12) begin
                            mon = 1;
                            // The year sticks at its maximum.
                            if (yr < YEAR_MAX) yr++;
                        end
                    end
                end
            end
        end
        ev[EV_TEN_SEC] = (sec % 10 == 0);
        if (ev[EV_MINUTE]) begin
            ev[EV_MIN5] = (mnt % 5 == 0);
            ev[EV_MIN10] = (mnt % 10 == 0);
            ev[EV_MIN15] = (mnt % 15 == 0);
        end
        if (ev[EV_HOUR]) begin
            ev[EV_HOUR2] = (hr % 2 == 0);
            ev[EV_MIDNIGHT] = (hr == 0);
        end
        cal_second = 6'(sec);
        cal_minute = 6'(mnt);
        cal_hour = 5'(hr);
        cal_day = 5'(dy);
        cal_month = 4'(mon);
        cal_year = 14'(yr);
    endtask

    task automatic apply_beat(input t_in_item it);
        t_out_item          res;
        logic [31:0]        diff;
        logic [31:0]        mag;
        logic [EVENT_W-1:0] ev;
        bit                 accepted;
        ev = '0;
        accepted = 1'b0;
        case (it.operation)
            OP_TICK: begin
                if (cfg_count_mode) begin
                    // Signed distance; a distance of exactly 2^31 keeps its magnitude.
                    diff = it.fine_count - fine_ref;
                    mag = diff[31] ? -diff : diff;
                    if (mag >= cfg_ticks) begin
                        fine_ref = it.fine_count;
                        advance_second(ev);
                    end
                end else begin
                    advance_second(ev);
                end
            end
            OP_SET: begin
                if (set_is_valid(it)) begin
                    cal_year = it.new_year;
                    cal_month = 4'(it.new_month);
                    cal_day = 5'(it.new_day);
                    cal_hour = 5'(it.new_hour);
                    cal_minute = 6'(it.new_minute);
                    cal_second = 6'(it.new_second);
                    accepted = 1'b1;
                end
            end
            default: ;
        endcase
        res.year = cal_year;
        res.month = cal_month;
        res.day = cal_day;
        res.hour = cal_hour;
        res.minute = cal_minute;
        res.second = cal_second;
        res.set_accepted = accepted;
        res.period_events = ev;
        calendar_readings.push_back(res);
    endtask

    task automatic send_beat(input t_in_item it);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
        apply_beat(it);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (calendar_readings.size() != 0) @(posedge i_clk);
    endtask

    // Writes both registers on back-to-back cycles; only called with the block idle.
    task automatic set_config(input logic mode, input logic [7:0] ticks);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_COUNT_MODE;
        i_cfg_wdata <= {7'd0, mode};
        @(posedge i_clk);
        i_cfg_idx <= CFG_TICKS_PER_SEC;
        i_cfg_wdata <= ticks;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_count_mode = mode;
        cfg_ticks = ticks;
    endtask

    function automatic t_in_item make_beat(input logic [1:0] op);
        t_in_item it;
        it.operation = op;
        it.fine_count = $urandom();
        it.new_year = 14'($urandom_range(0, 16383));
        it.new_month = 8'($urandom_range(0, 255));
        it.new_day = 8'($urandom_range(0, 255));
        it.new_hour = 8'($urandom_range(0, 255));
        it.new_minute = 8'($urandom_range(0, 255));
        it.new_second = 8'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic t_in_item set_beat(input int unsigned y, input int unsigned mo,
                                          input int unsigned d, input int unsigned h,
                                          input int unsigned mi, input int unsigned s);
        t_in_item it;
        it = make_beat(OP_SET);
        it.new_year = 14'(y);
        it.new_month = 8'(mo);
        it.new_day = 8'(d);
        it.new_hour = 8'(h);
        it.new_minute = 8'(mi);
        it.new_second = 8'(s);
        return it;
    endfunction

    function automatic t_in_item tick_beat(input logic [31:0] fine);
        t_in_item it;
        it = make_beat(OP_TICK);
        it.fine_count = fine;
        return it;
    endfunction

    // A valid set a few seconds short of a minute, often also of an hour, day or year.
    function automatic t_in_item near_rollover_set();
        int unsigned y;
        int unsigned mo;
        case ($urandom_range(0, 7))
            0: y = YEAR_MAX;
            1: y = 100 * $urandom_range(1, 99);
            default: y = $urandom_range(1, 9999);
        endcase
        mo = ($urandom_range(0, 3) == 0) ? 12 : $urandom_range(1, 12);
        return set_beat(y, mo,
                        $urandom_range(0, 1) ? month_length(mo, (y % 100) % 4 == 0)
                                             : $urandom_range(1, 28),
                        $urandom_range(0, 1) ? 23 : $urandom_range(0, 23),
                        $urandom_range(0, 1) ? 59 : $urandom_range(0, 59),
                        $urandom_range(50, 59));
    endfunction

    // Moves the fine counter mostly forward by about a second, sometimes back or anywhere.
    function automatic logic [31:0] next_fine();
        case ($urandom_range(0, 9))
            0: fine_now = $urandom();
            1: fine_now = fine_now - $urandom_range(0, 2 * cfg_ticks + 2);
            default: fine_now = fine_now + $urandom_range(0, 2 * cfg_ticks + 2);
        endcase
        return fine_now;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (calendar_readings.size() == 0) begin
                $error("result beat with no time pending");
                n_fail++;
            end else begin
                reading_due = calendar_readings.pop_front();
                check_field("year", 32'(reading_due.year), 32'(o_out_item.year));
                check_field("month", 32'(reading_due.month), 32'(o_out_item.month));
                check_field("day", 32'(reading_due.day), 32'(o_out_item.day));
                check_field("hour", 32'(reading_due.hour), 32'(o_out_item.hour));
                check_field("minute", 32'(reading_due.minute), 32'(o_out_item.minute));
                check_field("second", 32'(reading_due.second), 32'(o_out_item.second));
                check_field("set_accepted", 32'(reading_due.set_accepted),
                            32'(o_out_item.set_accepted));
                check_field("period_events", 32'(reading_due.period_events),
                            32'(o_out_item.period_events));
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic test_reset_state();
        send_beat(make_beat(OP_READ));
        send_beat(make_beat(OP_UNUSED));
    endtask

    task automatic test_calendar_rollover();
        // End of the last year: the year holds and the date wraps to January 1.
        send_beat(set_beat(9999, 12, 31, 23, 59, 59));
        send_beat(tick_beat($urandom()));
        send_beat(set_beat(2023, 12, 31, 23, 59, 59));
        send_beat(tick_beat($urandom()));
        // February 29 of 2100 passes the two-digit check but not the Gregorian rollover.
        send_beat(set_beat(2100, 2, 29, 23, 59, 59));
        send_beat(tick_beat($urandom()));
        send_beat(set_beat(2024, 2, 28, 23, 59, 59));
        send_beat(tick_beat($urandom()));
    endtask

    task automatic test_set_checks();
        send_beat(set_beat(0, 1, 1, 0, 0, 0));
        send_beat(set_beat(10000, 1, 1, 0, 0, 0));
        send_beat(set_beat(2023, 0, 1, 0, 0, 0));
        send_beat(set_beat(2023, 13, 1, 0, 0, 0));
        send_beat(set_beat(2023, 5, 0, 0, 0, 0));
        send_beat(set_beat(2023, 4, 31, 0, 0, 0));
        send_beat(set_beat(2023, 2, 29, 0, 0, 0));
        send_beat(set_beat(2023, 6, 15, 24, 0, 0));
        send_beat(set_beat(2023, 6, 15, 12, 60, 0));
        send_beat(set_beat(2023, 6, 15, 12, 30, 60));
        send_beat(set_beat(16383, 255, 255, 255, 255, 255));
        send_beat(set_beat(1, 1, 1, 0, 0, 0));
    endtask

    task automatic test_count_mode();
        drain_results();
        // With zero counts per second every tick advances, even with no movement.
        set_config(1'b1, 8'd0);
        send_beat(tick_beat(32'd0));
        drain_results();
        set_config(1'b1, 8'd255);
        send_beat(tick_beat(32'd254));
        // A counter that moved backward by enough still advances the second.
        send_beat(tick_beat(32'hFFFF_FF01));
        // A distance of exactly half the counter range counts as large.
        send_beat(tick_beat(32'h7FFF_FF01));
        fine_now = 32'h7FFF_FF01;
    endtask

    task automatic run_traffic(input int n_items);
        int       r;
        t_in_item it;
        repeat (n_items) begin
            r = $urandom_range(0, 99);
            if (r < 9) begin
                it = near_rollover_set();
            end else if (r < 13) begin
                it = make_beat(OP_SET);
            end else if (r < 18) begin
                it = make_beat(OP_READ);
            end else if (r < 20) begin
                it = make_beat(OP_UNUSED);
            end else begin
                it = tick_beat(next_fine());
            end
            send_beat(it);
        end
    endtask

    task automatic test_random_traffic();
        drain_results();
        set_config(1'b0, 8'd50);
        run_traffic(190);
        drain_results();
        set_config(1'b1, 8'd1);
        run_traffic(190);
        drain_results();
        set_config(1'b1, 8'd255);
        run_traffic(190);
        drain_results();
        set_config(1'b1, 8'($urandom_range(2, 254)));
        run_traffic(190);
        drain_results();
        set_config(1'b0, 8'($urandom_range(0, 255)));
        run_traffic(190);
    endtask

    task automatic test_full_rate();
        drain_results();
        quiet = 1'b1;
        set_config(1'b1, 8'($urandom_range(0, 255)));
        run_traffic(200);
    endtask

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        reset_calendar();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_calendar_rollover();
        test_set_checks();
        test_count_mode();
        test_random_traffic();
        test_full_rate();
        drain_results();
        repeat (4) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
